[design/emrs_pkg.sv]
// ----------------------------------------------------------------------------
// emrs_pkg: shared types and constants for the extent map request splitter
// Request and result layouts, table geometry, mode and status codes.
// ----------------------------------------------------------------------------
package emrs_pkg;

    // Table geometry.
    localparam int MAX_EXTENTS = 64;
    localparam int IDX_W       = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
    localparam int CNT_W       = $clog2(MAX_EXTENTS + 1);

    // A sector is 512 bytes, so byte values are sector values shifted by this.
    localparam int SECTOR_SHIFT = 9;
    localparam int LEN_W        = 32 + SECTOR_SHIFT;
    localparam int PHYS_W       = 57;

    // Request modes.
    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_XLATE  = 2'd2;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    // Result status codes.
    localparam logic [2:0] ST_SEG      = 3'd0;
    localparam logic [2:0] ST_ACK      = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_UNMAPPED = 3'd3;
    localparam logic [2:0] ST_RANOUT   = 3'd4;

    typedef struct packed {
        logic [1:0]  mode;
        logic [47:0] extent_file_offset;
        logic [47:0] extent_start_lba;
        logic [31:0] extent_sectors;
        logic [47:0] request_offset;
        logic [30:0] request_length;
    } emrs_req_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [31:0]       sequence_number;
        logic [7:0]        segment_device;
        logic [PHYS_W-1:0] physical_byte_offset;
        logic [30:0]       segment_length;
        logic              last;
    } emrs_res_t;

    // One stored extent.
    typedef struct packed {
        logic [47:0] file_offset;
        logic [47:0] lba;
        logic [31:0] sectors;
    } emrs_entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_in;
        logic       do_clear;
        logic       do_append;
        logic       rd_issue;
        logic       eval;
        logic       calc;
        logic       idx_inc;
        logic       set_found;
        logic       rem_sub;
        logic       seq_inc;
        logic       out_load;
        logic       out_seg;
        logic       out_last;
        logic [2:0] out_status;
    } emrs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] mode;
        logic       cnt_zero;
        logic       tbl_full;
        logic       last_idx;
        logic       hit;
        logic       rem_gt;
    } emrs_sts_t;

endpackage

[design/emrs_datapath.sv]
// ----------------------------------------------------------------------------
// emrs_datapath: extent table, walk arithmetic and result register
// Holds the extent memory, the request being split, the sequence number,
// the device id and the output register, all steered by controller commands.
// ----------------------------------------------------------------------------
module emrs_datapath
    import emrs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  emrs_cmd_t cmd,
    output emrs_sts_t sts,
    input  emrs_req_t s_data,
    input  logic      cfg_we,
    input  logic [7:0] cfg_data,
    output emrs_res_t m_data
);

    emrs_entry_t       mem [MAX_EXTENTS];
    emrs_entry_t       rd_q_reg;

    emrs_req_t         in_reg;
    logic [30:0]       rem_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              found_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [31:0]       seq_reg;
    logic [7:0]        dev_reg;

    logic [47:0]       diff_reg;
    logic              ge_reg;
    logic [PHYS_W-1:0] base_reg;
    logic [LEN_W-1:0]  len_reg;

    logic              hit_reg;
    logic [PHYS_W-1:0] phys_reg;
    logic [LEN_W-1:0]  avail_reg;

    emrs_res_t         res_reg;
    emrs_res_t         res_next;
    emrs_entry_t       wr_entry;

    logic [48:0]       diff_w;
    logic              lt_w;
    logic              rem_gt_w;

    // Control state: table fill, sequence number, device id.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            seq_reg   <= 32'd1;
            dev_reg   <= 8'd1;
        end else begin
            if (cfg_we) begin
                dev_reg <= cfg_data;
            end
            if (cmd.do_clear) begin
                count_reg <= '0;
                seq_reg   <= 32'd1;
            end else begin
                if (cmd.do_append) begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                if (cmd.seq_inc) begin
                    seq_reg <= seq_reg + 32'd1;
                end
            end
        end
    end

    assign wr_entry.file_offset = in_reg.extent_file_offset;
    assign wr_entry.lba         = in_reg.extent_start_lba;
    assign wr_entry.sectors     = in_reg.extent_sectors;

    // Extent memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (cmd.do_append) begin
            mem[count_reg[IDX_W-1:0]] <= wr_entry;
        end
        if (cmd.rd_issue) begin
            rd_q_reg <= mem[idx_reg];
        end
    end

    // Offset inside the extent; the borrow tells whether the request starts
    // at or after the extent's first byte.
    assign diff_w = {1'b0, in_reg.request_offset} - {1'b0, rd_q_reg.file_offset};
    assign lt_w   = diff_reg < {{(48 - LEN_W){1'b0}}, len_reg};
    assign rem_gt_w = {{(LEN_W - 31){1'b0}}, rem_reg} > avail_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_reg    <= s_data;
            rem_reg   <= s_data.request_length;
            idx_reg   <= '0;
            found_reg <= 1'b0;
        end else begin
            if (cmd.idx_inc) begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            if (cmd.set_found) begin
                found_reg <= 1'b1;
            end
            if (cmd.rem_sub) begin
                rem_reg <= rem_reg - avail_reg[30:0];
            end
        end
        if (cmd.eval) begin
            diff_reg <= diff_w[47:0];
            ge_reg   <= ~diff_w[48];
            base_reg <= {rd_q_reg.lba, {SECTOR_SHIFT{1'b0}}};
            len_reg  <= {rd_q_reg.sectors, {SECTOR_SHIFT{1'b0}}};
        end
        if (cmd.calc) begin
            hit_reg <= found_reg | (ge_reg & lt_w);
            if (found_reg) begin
                phys_reg  <= base_reg;
                avail_reg <= len_reg;
            end else begin
                phys_reg  <= base_reg + {{(PHYS_W - LEN_W){1'b0}}, diff_reg[LEN_W-1:0]};
                avail_reg <= len_reg - diff_reg[LEN_W-1:0];
            end
        end
        if (cmd.out_load) begin
            res_reg <= res_next;
        end
    end

    always_comb begin
        res_next.status          = cmd.out_status;
        res_next.sequence_number = cmd.do_clear ? 32'd1 : seq_reg;
        res_next.last            = cmd.out_last;
        if (cmd.out_seg) begin
            res_next.segment_device       = dev_reg;
            res_next.physical_byte_offset = phys_reg;
            res_next.segment_length       = rem_gt_w ? avail_reg[30:0] : rem_reg;
        end else begin
            res_next.segment_device       = '0;
            res_next.physical_byte_offset = '0;
            res_next.segment_length       = '0;
        end
    end

    assign sts.mode     = in_reg.mode;
    assign sts.cnt_zero = (count_reg == '0);
    assign sts.tbl_full = (count_reg == CNT_W'(MAX_EXTENTS));
    assign sts.last_idx = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign sts.hit      = hit_reg;
    assign sts.rem_gt   = rem_gt_w;

    assign m_data = res_reg;

endmodule

[design/emrs_ctrl.sv]
// ----------------------------------------------------------------------------
// emrs_ctrl: sequencing state machine of the extent map request splitter
// Accepts requests, steps the table walk and owns the result valid flag.
// ----------------------------------------------------------------------------
module emrs_ctrl
    import emrs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic [1:0] s_mode,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  emrs_sts_t  sts,
    output emrs_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ACK    = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_EVAL   = 3'd3;
    localparam logic [2:0] S_CALC   = 3'd4;
    localparam logic [2:0] S_DECIDE = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;

    assign slot_free = ~out_valid_reg | m_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    case (s_mode)
                        MODE_CLEAR, MODE_APPEND: state_next = S_ACK;
                        MODE_XLATE:  state_next = sts.cnt_zero ? S_ACK : S_READ;
                        default:     state_next = S_IDLE;
                    endcase
                end
            end
            S_ACK: begin
                if (slot_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = 1'b1;
                    case (sts.mode)
                        MODE_CLEAR: begin
                            cmd.do_clear   = 1'b1;
                            cmd.out_status = ST_ACK;
                        end
                        MODE_APPEND: begin
                            if (sts.tbl_full) begin
                                cmd.out_status = ST_FULL;
                            end else begin
                                cmd.do_append  = 1'b1;
                                cmd.out_status = ST_ACK;
                            end
                        end
                        default: begin
                            cmd.out_status = ST_UNMAPPED;
                        end
                    endcase
                    state_next = S_IDLE;
                end
            end
            S_READ: begin
                cmd.rd_issue = 1'b1;
                state_next   = S_EVAL;
            end
            S_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = S_CALC;
            end
            S_CALC: begin
                cmd.calc   = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                if (sts.hit) begin
                    if (slot_free) begin
                        cmd.out_load = 1'b1;
                        cmd.out_seg  = 1'b1;
                        if (!sts.rem_gt) begin
                            cmd.out_status = ST_SEG;
                            cmd.out_last   = 1'b1;
                            cmd.seq_inc    = 1'b1;
                            state_next     = S_IDLE;
                        end else if (sts.last_idx) begin
                            cmd.out_status = ST_RANOUT;
                            cmd.out_last   = 1'b1;
                            state_next     = S_IDLE;
                        end else begin
                            cmd.out_status = ST_SEG;
                            cmd.rem_sub    = 1'b1;
                            cmd.idx_inc    = 1'b1;
                            cmd.set_found  = 1'b1;
                            state_next     = S_READ;
                        end
                    end
                end else if (sts.last_idx) begin
                    if (slot_free) begin
                        cmd.out_load   = 1'b1;
                        cmd.out_last   = 1'b1;
                        cmd.out_status = ST_UNMAPPED;
                        state_next     = S_IDLE;
                    end
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_READ;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

[design/extent_map_request_splitter_unit.sv]
// ----------------------------------------------------------------------------
// extent_map_request_splitter_unit: file extent table and request splitter
// A clear, an append, or a translate on an empty table loads its result from
// the ack state after acceptance; a translate visits table entries from
// entry 0, each through the memory read, offset subtract, bound compare and
// address add, and split decision states, and a result is held back while the
// output register still holds one that the consumer has not taken.
// Throughput: one request at a time; the next is taken once the last result is
// in the output register. Reset (aresetn low, synchronous) empties the table,
// sets the sequence number to 1 and the device id to 1; no clearing pass.
// ----------------------------------------------------------------------------
module extent_map_request_splitter_unit
    import emrs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    output logic       s_ready,
    input  emrs_req_t  s_data,

    output logic       m_valid,
    input  logic       m_ready,
    output emrs_res_t  m_data,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    // The controller and the datapath talk only through these two structs.
    emrs_cmd_t cmd;
    emrs_sts_t sts;

    // The device id register can be written in any cycle; the user must keep the block only
    // written while idle, so a write never lands in the middle of a request (not enforced).
    assign cfg_ready = 1'b1;

    // The controller walks the table one entry at a time. It accepts a new
    // request only when idle, but the output register decouples it from the
    // result consumer: the next request is taken while the last result of
    // the previous one still waits for m_ready.
    emrs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_mode  (s_data.mode),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // The datapath stores the extents in a single-port-read memory and does
    // the offset arithmetic. Each segment starts either inside the first
    // matching extent or at the beginning of a later one, and its length is
    // the smaller of the bytes still requested and the bytes left in it.
    emrs_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_data   (s_data),
        .cfg_we   (cfg_valid & cfg_ready),
        .cfg_data (cfg_data),
        .m_data   (m_data)
    );

    // An accepted request that does real work keeps the input closed for at
    // least the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_data.mode != MODE_NONE)) |=> !s_ready)
        else $error("input reopened right after accepting a request");

    // A new result is never loaded over one that the consumer has not taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid || m_ready))
        else $error("result register overwritten while still pending");

    // Every status other than a plain segment ends the request's results.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status != ST_SEG)) |-> m_data.last)
        else $error("non-segment result without last");

endmodule
